// ----- src/rip_pkg.sv -----
// package for the regex infix-to-postfix converter
// item types, operator codes and character tables shared by front, back and top
`timescale 1ns / 1ps

package rip_pkg;

    // default operator stack depth
    localparam int STACK_DEPTH_DEF = 32;

    // ascii codes of the operator characters
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    // operator codes as kept on the stack
    localparam logic [1:0] OP_LPAREN = 2'd0;
    localparam logic [1:0] OP_STAR   = 2'd1;
    localparam logic [1:0] OP_DOT    = 2'd2;
    localparam logic [1:0] OP_BAR    = 2'd3;

    // input item
    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_expr;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [7:0] out_symbol;
        logic       has_symbol;
        logic       last_of_expr;
        logic       syntax_error;
    } t_out_item;

    // class of an accepted character
    typedef enum logic [1:0] {
        K_LIT,
        K_LPAREN,
        K_RPAREN,
        K_OP
    } t_kind;

    // classified item handed from front to back
    typedef struct packed {
        t_kind      kind;
        logic [1:0] op;
        logic [7:0] ch;
        logic       last;
    } t_cmd;

    // character for an operator code
    function automatic logic [7:0] op_char(input logic [1:0] code);
        logic [7:0] ch;
        unique case (code)
            OP_LPAREN: ch = CH_LPAREN;
            OP_STAR:   ch = CH_STAR;
            OP_DOT:    ch = CH_DOT;
            default:   ch = CH_BAR;
        endcase
        return ch;
    endfunction

    // binding strength of an operator code, '(' lowest
    function automatic logic [1:0] op_prec(input logic [1:0] code);
        logic [1:0] p;
        unique case (code)
            OP_LPAREN: p = 2'd0;
            OP_STAR:   p = 2'd3;
            OP_DOT:    p = 2'd2;
            default:   p = 2'd1;
        endcase
        return p;
    endfunction

endpackage

// ----- src/regex_infix_to_postfix_top.sv -----
// top level of the regex infix-to-postfix converter
// depends on rip_pkg, rip_front and rip_back
`timescale 1ns / 1ps

// Converts a regex with explicit '.' concatenation, one character per item,
// into postfix characters using an operator stack ('*' over '.' over '|').
// Input channel: i_in_valid / o_in_stall with an i_in_item struct; an item is
// taken at an edge with valid high and stall low. A two-entry queue sits in
// front, so up to two items are taken while the stack logic is busy.
// Output channel: o_out_valid / i_out_stall with an o_out_item struct from a
// single output register. A literal passes from the input queue through the
// idle and literal states into that register. Each operator popped from the
// stack waits for the stack memory's registered top-of-stack read, which is
// stale right after every push or pop. An item with end_of_expr set flushes
// the stack, and the final result carries last_of_expr (an end marker with
// has_symbol low if nothing else was released). syntax_error is sticky
// across expressions. Reset clears the stack count and the error flag; stack
// contents are not cleared. While the receiver stalls, the result holds and
// the sequencer waits; the input queue fills and then raises o_in_stall.
module regex_infix_to_postfix_top import rip_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    // classify and queue
    rip_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    // stack sequencer
    rip_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ----- src/rip_front.sv -----
// front end: accepts input items, classifies each character and queues it
// depends on rip_pkg
`timescale 1ns / 1ps

module rip_front import rip_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    output logic     o_cmd_valid,
    input  logic     i_cmd_pop,
    output t_cmd     o_cmd
);

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    t_cmd       cls;
    logic       push;
    logic       pop;

    // classify the incoming character
    always_comb begin
        cls.ch   = i_in_item.symbol;
        cls.last = i_in_item.end_of_expr;
        unique case (i_in_item.symbol)
            CH_LPAREN: begin
                cls.kind = K_LPAREN;
                cls.op   = OP_LPAREN;
            end
            CH_RPAREN: begin
                cls.kind = K_RPAREN;
                cls.op   = OP_LPAREN;
            end
            CH_STAR: begin
                cls.kind = K_OP;
                cls.op   = OP_STAR;
            end
            CH_DOT: begin
                cls.kind = K_OP;
                cls.op   = OP_DOT;
            end
            CH_BAR: begin
                cls.kind = K_OP;
                cls.op   = OP_BAR;
            end
            default: begin
                cls.kind = K_LIT;
                cls.op   = OP_LPAREN;
            end
        endcase
    end

    // two-entry queue toward the back end
    assign o_in_stall  = (r_fill == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_cmd_pop && (r_fill != 2'd0);
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

// ----- src/rip_back.sv -----
// back end: operator stack sequencer that pops, pushes and flushes per item
// depends on rip_pkg; owns the stack memory and the output register
`timescale 1ns / 1ps

module rip_back import rip_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_pop,
    input  t_cmd      i_cmd,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIT,
        S_PUSH,
        S_OP,
        S_RPAR,
        S_FLUSH
    } t_state;

    t_state     r_state, n_state;
    t_cmd       r_cmd, n_cmd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_lp, n_lp;
    logic       r_err, n_err;
    logic       r_emitted, n_emitted;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out_item, n_out_item;
    logic [1:0] r_stack [STACK_DEPTH];
    logic [1:0] r_top;
    logic       r_top_ok;
    logic       wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic       full;
    logic       emit_ok;
    logic       cnt_one;
    logic       rpar_end;

    assign full    = (r_cnt == CNT_W'(STACK_DEPTH));
    assign emit_ok = !r_out_valid || !i_out_stall;
    assign cnt_one = (r_cnt == CNT_W'(1));
    assign wr_idx  = r_cnt[IDX_W-1:0];
    assign rd_idx  = (r_cnt == '0) ? '0 : IDX_W'(r_cnt - CNT_W'(1));

    // popped operator leaves nothing behind: either the stack bottom, or the
    // only open paren sits right below it at the bottom
    assign rpar_end = cnt_one || ((r_cnt == CNT_W'(2)) && (r_lp == CNT_W'(1)));

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_cnt       = r_cnt;
        n_lp        = r_lp;
        n_err       = r_err;
        n_emitted   = r_emitted;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        wr_en       = 1'b0;
        o_cmd_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_emitted = 1'b0;
                    unique case (i_cmd.kind)
                        K_LIT:    n_state = S_LIT;
                        K_LPAREN: n_state = S_PUSH;
                        K_RPAREN: begin
                            // no open paren anywhere on the stack
                            if (r_lp == '0) begin
                                n_err = 1'b1;
                            end
                            n_state = S_RPAR;
                        end
                        default:  n_state = S_OP;
                    endcase
                end
            end
            S_LIT: begin
                if (emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out_item  = '{out_symbol: r_cmd.ch, has_symbol: 1'b1,
                                    last_of_expr: r_cmd.last && (r_cnt == '0),
                                    syntax_error: r_err};
                    n_emitted   = 1'b1;
                    n_state     = (r_cmd.last && (r_cnt != '0)) ? S_FLUSH : S_IDLE;
                end
            end
            S_PUSH: begin
                // overflow drops the operator
                if (full) begin
                    n_err = 1'b1;
                end else begin
                    wr_en = 1'b1;
                    n_cnt = r_cnt + CNT_W'(1);
                    if (r_cmd.op == OP_LPAREN) begin
                        n_lp = r_lp + CNT_W'(1);
                    end
                end
                n_state = r_cmd.last ? S_FLUSH : S_IDLE;
            end
            S_OP: begin
                // pop while the top binds at least as strongly
                if (r_cnt == '0) begin
                    n_state = S_PUSH;
                end else if (r_top_ok) begin
                    if (r_top == OP_LPAREN || op_prec(r_top) < op_prec(r_cmd.op)) begin
                        n_state = S_PUSH;
                    end else if (emit_ok) begin
                        n_out_valid = 1'b1;
                        n_out_item  = '{out_symbol: op_char(r_top), has_symbol: 1'b1,
                                        last_of_expr: 1'b0, syntax_error: r_err};
                        n_emitted   = 1'b1;
                        n_cnt       = r_cnt - CNT_W'(1);
                    end
                end
            end
            S_RPAR: begin
                // pop down to the matching paren and drop it
                if (r_cnt == '0) begin
                    n_state = r_cmd.last ? S_FLUSH : S_IDLE;
                end else if (r_top_ok) begin
                    if (r_top == OP_LPAREN) begin
                        n_cnt   = r_cnt - CNT_W'(1);
                        n_lp    = r_lp - CNT_W'(1);
                        n_state = r_cmd.last ? S_FLUSH : S_IDLE;
                    end else if (emit_ok) begin
                        n_out_valid = 1'b1;
                        n_out_item  = '{out_symbol: op_char(r_top), has_symbol: 1'b1,
                                        last_of_expr: r_cmd.last && rpar_end,
                                        syntax_error: r_err};
                        n_emitted   = 1'b1;
                        n_cnt       = r_cnt - CNT_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                // empty the stack; end marker if the item gave nothing
                if (r_cnt == '0) begin
                    if (r_emitted) begin
                        n_state = S_IDLE;
                    end else if (emit_ok) begin
                        n_out_valid = 1'b1;
                        n_out_item  = '{out_symbol: 8'h00, has_symbol: 1'b0,
                                        last_of_expr: 1'b1, syntax_error: r_err};
                        n_emitted   = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (r_top_ok && emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out_item  = '{out_symbol: op_char(r_top), has_symbol: 1'b1,
                                    last_of_expr: cnt_one, syntax_error: r_err};
                    n_emitted   = 1'b1;
                    n_cnt       = r_cnt - CNT_W'(1);
                    if (r_top == OP_LPAREN) begin
                        n_lp = r_lp - CNT_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // stack memory with registered top read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[wr_idx] <= r_cmd.op;
        end
        r_top <= r_stack[rd_idx];
    end

    // state, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_lp        <= '0;
            r_err       <= 1'b0;
            r_emitted   <= 1'b0;
            r_out_valid <= 1'b0;
            r_top_ok    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_lp        <= n_lp;
            r_err       <= n_err;
            r_emitted   <= n_emitted;
            r_out_valid <= n_out_valid;
            // top read is stale right after any stack change
            r_top_ok    <= !(wr_en || (n_cnt != r_cnt));
        end
        r_cmd      <= n_cmd;
        r_out_item <= n_out_item;
    end

endmodule

// ----- tb/tb_top.sv -----
// testbench for the regex infix-to-postfix converter, top module tb_top
// depends on rip_pkg and regex_infix_to_postfix_top; self-checking against its own stack predictor
`timescale 1ns / 1ps

module tb_top;
    import rip_pkg::*;

    localparam int STK_DEPTH = STACK_DEPTH_DEF;
    localparam int N_ITEMS   = 450;
    localparam int N_CLEAN   = 280;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  in_item = '0;
    logic      o_out_valid;
    logic      out_stall = 1'b0;
    t_out_item o_out_item;

    regex_infix_to_postfix_top #(
        .STACK_DEPTH(STK_DEPTH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item(in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item(o_out_item)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // items waiting to be driven, expected postfix results, scratch for expressions
    t_in_item   src_items[$];
    t_out_item  postfix_q[$];
    logic [7:0] expr_buf[$];

    // predictor state
    logic [1:0] op_stack_m[0:STK_DEPTH-1];
    int         op_depth = 0;
    bit         err_sticky = 1'b0;

    // statistics and failures
    int n_accepted = 0;
    int n_results = 0;
    int n_markers = 0;
    int n_flagged = 0;
    int max_burst = 0;
    int n_bad = 0;

    // handshake pacing
    int in_gap = 0;
    int stall_left = 0;
    bit in_burst = 1'b0;
    bit out_burst = 1'b0;
    t_out_item want;

    // idle length: mostly none, some short, a few long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic bit is_operator(logic [7:0] c);
        return c == CH_LPAREN || c == CH_RPAREN || c == CH_STAR || c == CH_DOT || c == CH_BAR;
    endfunction

    // character for each operator code kept on the stack
    function automatic logic [7:0] char_of(logic [1:0] code);
        case (code)
            OP_LPAREN: return CH_LPAREN;
            OP_STAR:   return CH_STAR;
            OP_DOT:    return CH_DOT;
            default:   return CH_BAR;
        endcase
    endfunction

    // binding strength, star highest, bar lowest
    function automatic int rank_of(logic [1:0] code);
        case (code)
            OP_STAR: return 3;
            OP_DOT:  return 2;
            OP_BAR:  return 1;
            default: return 0;
        endcase
    endfunction

    function automatic void push_stack(logic [1:0] code);
        if (op_depth >= STK_DEPTH) begin
            err_sticky = 1'b1;
        end else begin
            op_stack_m[op_depth] = code;
            op_depth++;
        end
    endfunction

    // shunting-yard step for one accepted item, expected results go to postfix_q
    function automatic void predict_postfix(t_in_item it);
        t_out_item  rel[$];
        t_out_item  r;
        logic [1:0] code;
        bit         found;
        r = '0;
        found = 1'b0;
        r.has_symbol = 1'b1;
        case (it.symbol)
            CH_LPAREN: begin
                push_stack(OP_LPAREN);
            end
            CH_RPAREN: begin
                while (op_depth > 0) begin
                    op_depth--;
                    if (op_stack_m[op_depth] == OP_LPAREN) begin
                        found = 1'b1;
                        break;
                    end
                    r.out_symbol = char_of(op_stack_m[op_depth]);
                    rel.push_back(r);
                end
                if (!found)
                    err_sticky = 1'b1;
            end
            CH_STAR, CH_DOT, CH_BAR: begin
                code = (it.symbol == CH_STAR) ? OP_STAR :
                       (it.symbol == CH_DOT) ? OP_DOT : OP_BAR;
                while (op_depth > 0 && op_stack_m[op_depth-1] != OP_LPAREN &&
                       rank_of(op_stack_m[op_depth-1]) >= rank_of(code)) begin
                    op_depth--;
                    r.out_symbol = char_of(op_stack_m[op_depth]);
                    rel.push_back(r);
                end
                push_stack(code);
            end
            default: begin
                r.out_symbol = it.symbol;
                rel.push_back(r);
            end
        endcase
        // end of expression: flush everything, leftover '(' included
        if (it.end_of_expr) begin
            while (op_depth > 0) begin
                op_depth--;
                r.out_symbol = char_of(op_stack_m[op_depth]);
                rel.push_back(r);
            end
            if (rel.size() == 0) begin
                rel.push_back('0);
                n_markers++;
            end
            rel[rel.size()-1].last_of_expr = 1'b1;
        end
        if (rel.size() > max_burst)
            max_burst = rel.size();
        foreach (rel[k]) begin
            rel[k].syntax_error = err_sticky;
            postfix_q.push_back(rel[k]);
        end
        n_accepted++;
    endfunction

    // driver: next item from src_items, held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!(in_valid && o_in_stall)) begin
            if (in_valid)
                predict_postfix(in_item);
            if ($urandom_range(0, 49) == 0)
                in_burst = !in_burst;
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (src_items.size() != 0) begin
                in_item <= src_items.pop_front();
                in_valid <= 1'b1;
                in_gap = in_burst ? 0 : pick_idle();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each accepted result against the oldest expectation, random stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            n_results++;
            if (o_out_item.syntax_error === 1'b1)
                n_flagged++;
            if (postfix_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("tb: unexpected result sym=%h has=%b last=%b err=%b",
                             o_out_item.out_symbol, o_out_item.has_symbol,
                             o_out_item.last_of_expr, o_out_item.syntax_error);
            end else begin
                want = postfix_q.pop_front();
                if (o_out_item.out_symbol !== want.out_symbol ||
                    o_out_item.has_symbol !== want.has_symbol ||
                    o_out_item.last_of_expr !== want.last_of_expr ||
                    o_out_item.syntax_error !== want.syntax_error) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display({"tb: mismatch at result %0d: ",
                                  "exp sym=%h has=%b last=%b err=%b, ",
                                  "got sym=%h has=%b last=%b err=%b"},
                                 n_results, want.out_symbol, want.has_symbol,
                                 want.last_of_expr, want.syntax_error,
                                 o_out_item.out_symbol, o_out_item.has_symbol,
                                 o_out_item.last_of_expr, o_out_item.syntax_error);
                end
            end
        end
        if ($urandom_range(0, 99) == 0)
            out_burst = !out_burst;
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
            if (!out_burst && $urandom_range(0, 3) == 0)
                stall_left = pick_idle();
        end
    end

    task automatic put_item(logic [7:0] sym, bit last);
        t_in_item it;
        it.symbol = sym;
        it.end_of_expr = last;
        src_items.push_back(it);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_item(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_literal();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_operator(c));
        return c;
    endfunction

    // random well-formed regex with explicit concatenation, nesting limited by lvl
    task automatic gen_alt(int lvl);
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            if (i > 0)
                expr_buf.push_back(CH_BAR);
            gen_cat(lvl);
        end
    endtask

    task automatic gen_cat(int lvl);
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            if (i > 0)
                expr_buf.push_back(CH_DOT);
            gen_fac(lvl);
        end
    endtask

    task automatic gen_fac(int lvl);
        if (lvl > 0 && $urandom_range(0, 3) == 0) begin
            expr_buf.push_back(CH_LPAREN);
            gen_alt(lvl - 1);
            expr_buf.push_back(CH_RPAREN);
        end else begin
            expr_buf.push_back(rand_literal());
        end
        if ($urandom_range(0, 2) == 0)
            expr_buf.push_back(CH_STAR);
        if ($urandom_range(0, 9) == 0)
            expr_buf.push_back(CH_STAR);
    endtask

    task automatic put_random_expr();
        expr_buf.delete();
        gen_alt(3);
        foreach (expr_buf[i])
            put_item(expr_buf[i], i == expr_buf.size() - 1);
    endtask

    // deep '(' run, overflows the stack when longer than its depth
    task automatic put_deep_nest(int depth);
        int closes;
        closes = $urandom_range(0, depth);
        for (int i = 0; i < depth; i++)
            put_item(CH_LPAREN, 1'b0);
        put_item(rand_literal(), closes == 0);
        for (int i = 0; i < closes; i++)
            put_item(CH_RPAREN, i == closes - 1);
    endtask

    // stimulus and end of run
    initial begin
        int r;
        int n;
        // directed, error-free: extreme literals, every operator, precedence,
        // grouping and unmatched '(' at end
        put_item(8'h00, 1'b1);
        put_item(8'hFF, 1'b1);
        put_text("a.b*|c");
        put_text("(a|b)*.c");
        put_text("a|b|c");
        put_text("(a)");
        put_text("(");
        put_text("x.(y");
        // random well-formed expressions while the error flag is still clear
        while (src_items.size() < N_CLEAN)
            put_random_expr();
        // broken sequences: lone ')' with empty end, unmatched ')', overflow
        put_text(")");
        put_text("a|b)");
        put_deep_nest(STK_DEPTH + 1);
        // mix of well-formed expressions, noise and deep nests
        while (src_items.size() < N_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                put_random_expr();
            end else if (r < 9) begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 9))
                        0: put_item(CH_LPAREN, $urandom_range(0, 3) == 0);
                        1: put_item(CH_RPAREN, $urandom_range(0, 3) == 0);
                        2: put_item(CH_STAR, $urandom_range(0, 3) == 0);
                        3: put_item(CH_DOT, $urandom_range(0, 3) == 0);
                        4: put_item(CH_BAR, $urandom_range(0, 3) == 0);
                        default: put_item(8'($urandom_range(0, 255)),
                                          $urandom_range(0, 3) == 0);
                    endcase
                end
            end else begin
                put_deep_nest($urandom_range(20, STK_DEPTH + 8));
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (src_items.size() != 0 || in_valid)
            @(posedge i_clk);
        while (postfix_q.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("tb: %0d items in, %0d results checked, %0d end markers, %0d with error set",
                 n_accepted, n_results, n_markers, n_flagged);
        $display("tb: largest release from one item was %0d results", max_burst);
        if (n_bad == 0 && postfix_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches, %0d results still owed", n_bad, postfix_q.size());
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #15_000_000;
        $display("tb: timeout, %0d results still owed", postfix_q.size());
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
src/rip_pkg.sv
src/rip_front.sv
src/rip_back.sv
src/regex_infix_to_postfix_top.sv
tb/tb_top.sv
